[rtl/point_in_oriented_box_contact_core_assert.svh]
// assertion macros for the oriented box contact core
`ifndef POINT_IN_ORIENTED_BOX_CONTACT_CORE_ASSERT_SVH
`define POINT_IN_ORIENTED_BOX_CONTACT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define POBC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: assertion failed");
`define POBC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error("%m: assertion failed");
`else
`define POBC_ASSERT(lbl, prop)
`define POBC_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

[rtl/pobc_pkg.sv]
// shared types, constants and field helpers for the oriented box contact core
package pobc_pkg;

  localparam int COORD_W  = 16;
  localparam int ROT_W    = 16;
  localparam int ROT_FRAC = 14;
  localparam int CFG_W    = 3 * ROT_W;
  localparam int IDX_W    = 3;

  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = DIFF_W + ROT_W;
  localparam int LOC_W  = PROD_W + 2;

  localparam logic [CFG_W-1:0] CENTER_RST = '0;
  localparam logic [CFG_W-1:0] COL_X_RST  = CFG_W'(64'd16384);
  localparam logic [CFG_W-1:0] COL_Y_RST  = CFG_W'(64'd16384 << ROT_W);
  localparam logic [CFG_W-1:0] COL_Z_RST  = CFG_W'(64'd16384 << (2 * ROT_W));
  localparam logic [CFG_W-1:0] SIZE_RST   =
    CFG_W'((64'd256 << (2 * COORD_W)) | (64'd256 << COORD_W) | 64'd256);

  typedef enum logic [IDX_W-1:0] {
    REG_BOX_CENTER = 3'd0,
    REG_AXIS_COL_X = 3'd1,
    REG_AXIS_COL_Y = 3'd2,
    REG_AXIS_COL_Z = 3'd3,
    REG_BOX_SIZE   = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] query_x;
    logic signed [COORD_W-1:0] query_y;
    logic signed [COORD_W-1:0] query_z;
  } query_t;

  typedef struct packed {
    logic                      hit;
    logic signed [ROT_W-1:0]   normal_x;
    logic signed [ROT_W-1:0]   normal_y;
    logic signed [ROT_W-1:0]   normal_z;
    logic signed [COORD_W-1:0] contact_x;
    logic signed [COORD_W-1:0] contact_y;
    logic signed [COORD_W-1:0] contact_z;
  } result_t;

  typedef struct packed {
    logic [CFG_W-1:0] col_z;
    logic [CFG_W-1:0] col_y;
    logic [CFG_W-1:0] col_x;
  } axes_t;

  typedef struct packed {
    logic signed [LOC_W-1:0] v_z;
    logic signed [LOC_W-1:0] v_y;
    logic signed [LOC_W-1:0] v_x;
  } frame_t;

  function automatic logic signed [ROT_W-1:0] rot_elem(input logic [CFG_W-1:0] col,
                                                        input int unsigned row);
    return col[row*ROT_W +: ROT_W];
  endfunction

  function automatic logic signed [COORD_W-1:0] coord_elem(input logic [CFG_W-1:0] word,
                                                            input int unsigned row);
    return word[row*COORD_W +: COORD_W];
  endfunction

endpackage

[rtl/point_in_oriented_box_contact_core.sv]
// top level: oriented box point test with nearest face normal and contact point
//
// Query points enter on start/query; a beat is taken at each rising edge with
// start high and busy low. busy is high only during reset and the cycle after it,
// so a new point can enter every cycle.
// Each point gives one result beat on result, marked by done for one cycle.
// The pipeline has seven register stages: center subtract, rotation
// products, dot sums, face margins, face select, contact scaling, contact
// add and saturate; it never stalls, and the receiver cannot hold results off.
// Box center, rotation columns and extents are written through wr_en,
// wr_index and wr_data; the user must write only while no point is in
// flight, which the block does not enforce. Unknown indexes are ignored.
// Reset loads the unit box at the origin and clears all in-flight beats.
`include "point_in_oriented_box_contact_core_assert.svh"
module point_in_oriented_box_contact_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  pobc_pkg::query_t              query,
  output logic                          done,
  output pobc_pkg::result_t             result,
  input  logic                          wr_en,
  input  logic [pobc_pkg::IDX_W-1:0]    wr_index,
  input  logic [pobc_pkg::CFG_W-1:0]    wr_data
);
  import pobc_pkg::*;

  localparam int MARGIN_W = LOC_W + 2;
  localparam int SCALE_W  = ROT_W + COORD_W + 1;
  localparam int OFF_W    = SCALE_W + 1 - (ROT_FRAC + 1);
  localparam int CSUM_W   = OFF_W + 1;
  localparam int LATENCY  = 7;

  localparam logic signed [ROT_W-1:0]    ROT_MAX   = {1'b0, {(ROT_W-1){1'b1}}};
  localparam logic signed [ROT_W-1:0]    ROT_MIN   = {1'b1, {(ROT_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0]  COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0]  COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [CSUM_W-1:0]   CSUM_MAX  = CSUM_W'(COORD_MAX);
  localparam logic signed [CSUM_W-1:0]   CSUM_MIN  = -CSUM_MAX - CSUM_W'(1);
  localparam logic signed [SCALE_W:0]    ROUND_ADD = (SCALE_W+1)'(1) <<< ROT_FRAC;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  logic [CFG_W-1:0] box_center;
  logic [CFG_W-1:0] box_size;
  axes_t            axes;
  logic             accept;
  logic             fr_valid;
  frame_t           frame;

  logic signed [LOC_W-1:0]    vloc      [3];
  logic [LOC_W-1:0]           mag       [3];
  logic signed [MARGIN_W-1:0] margin    [3];
  logic [CFG_W-1:0]           col       [3];

  logic                       s4_valid;
  logic signed [MARGIN_W-1:0] s4_margin [3];
  logic [2:0]                 s4_neg;

  axis_t                      axis;
  logic                       in_box;
  logic [CFG_W-1:0]           sel_col;
  logic                       sel_neg;
  logic [COORD_W-1:0]         sel_size;

  logic                       s5_valid;
  logic                       s5_hit;
  logic signed [ROT_W-1:0]    s5_n      [3];
  logic [COORD_W-1:0]         s5_size;

  logic                       s6_valid;
  logic                       s6_hit;
  logic signed [ROT_W-1:0]    s6_n      [3];
  logic signed [SCALE_W-1:0]  s6_prod   [3];

  logic signed [SCALE_W:0]    rsum      [3];
  logic signed [OFF_W-1:0]    off       [3];
  logic signed [CSUM_W-1:0]   csum      [3];
  logic signed [COORD_W-1:0]  contact   [3];
  result_t                    result_next;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b1;
      box_center <= CENTER_RST;
      axes.col_x <= COL_X_RST;
      axes.col_y <= COL_Y_RST;
      axes.col_z <= COL_Z_RST;
      box_size   <= SIZE_RST;
    end else begin
      busy <= 1'b0;
      if (wr_en) begin
        unique case (wr_index)
          REG_BOX_CENTER: box_center <= wr_data;
          REG_AXIS_COL_X: axes.col_x <= wr_data;
          REG_AXIS_COL_Y: axes.col_y <= wr_data;
          REG_AXIS_COL_Z: axes.col_z <= wr_data;
          REG_BOX_SIZE:   box_size   <= wr_data;
          default: ;
        endcase
      end
    end
  end

  pobc_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .query     (query),
    .center    (box_center),
    .axes      (axes),
    .out_valid (fr_valid),
    .frame     (frame)
  );

  assign vloc[0] = frame.v_x;
  assign vloc[1] = frame.v_y;
  assign vloc[2] = frame.v_z;
  assign col[0]  = axes.col_x;
  assign col[1]  = axes.col_y;
  assign col[2]  = axes.col_z;

  // face margins: full extent scaled to the rotation fraction minus twice |v|
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      mag[j]    = vloc[j][LOC_W-1] ? LOC_W'(-vloc[j]) : LOC_W'(vloc[j]);
      margin[j] = $signed({{(MARGIN_W-COORD_W-ROT_FRAC){1'b0}},
                           box_size[j*COORD_W +: COORD_W], {ROT_FRAC{1'b0}}})
                - $signed({1'b0, mag[j], 1'b0});
    end
  end

  // nearest face select; ties fall to the later axis
  always_comb begin
    in_box = 1'b1;
    for (int j = 0; j < 3; j++) begin
      if (s4_margin[j] <= 0) begin
        in_box = 1'b0;
      end
    end
    if (s4_margin[0] < s4_margin[1]) begin
      axis = (s4_margin[0] < s4_margin[2]) ? AXIS_X : AXIS_Z;
    end else begin
      axis = (s4_margin[1] < s4_margin[2]) ? AXIS_Y : AXIS_Z;
    end
    unique case (axis)
      AXIS_X: begin
        sel_col  = col[0];
        sel_neg  = s4_neg[0];
        sel_size = box_size[0 +: COORD_W];
      end
      AXIS_Y: begin
        sel_col  = col[1];
        sel_neg  = s4_neg[1];
        sel_size = box_size[COORD_W +: COORD_W];
      end
      default: begin
        sel_col  = col[2];
        sel_neg  = s4_neg[2];
        sel_size = box_size[2*COORD_W +: COORD_W];
      end
    endcase
  end

  // contact: round half up, floor shift, then saturate center plus offset
  always_comb begin
    result_next = '0;
    for (int i = 0; i < 3; i++) begin
      rsum[i] = (SCALE_W+1)'(s6_prod[i]) + ROUND_ADD;
      off[i]  = rsum[i][SCALE_W:ROT_FRAC+1];
      csum[i] = CSUM_W'(coord_elem(box_center, i)) + CSUM_W'(off[i]);
      if (csum[i] > CSUM_MAX) begin
        contact[i] = COORD_MAX;
      end else if (csum[i] < CSUM_MIN) begin
        contact[i] = COORD_MIN;
      end else begin
        contact[i] = csum[i][COORD_W-1:0];
      end
    end
    if (s6_hit) begin
      result_next.hit       = 1'b1;
      result_next.normal_x  = s6_n[0];
      result_next.normal_y  = s6_n[1];
      result_next.normal_z  = s6_n[2];
      result_next.contact_x = contact[0];
      result_next.contact_y = contact[1];
      result_next.contact_z = contact[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s4_valid <= fr_valid;
      s5_valid <= s4_valid;
      s6_valid <= s5_valid;
      done     <= s6_valid;
    end
    for (int j = 0; j < 3; j++) begin
      s4_margin[j] <= margin[j];
      s4_neg[j]    <= vloc[j][LOC_W-1];
    end
    s5_hit  <= in_box;
    s5_size <= sel_size;
    for (int i = 0; i < 3; i++) begin
      if (!sel_neg) begin
        s5_n[i] <= rot_elem(sel_col, i);
      end else if (rot_elem(sel_col, i) == ROT_MIN) begin
        s5_n[i] <= ROT_MAX;
      end else begin
        s5_n[i] <= -rot_elem(sel_col, i);
      end
    end
    s6_hit <= s5_hit;
    for (int i = 0; i < 3; i++) begin
      s6_n[i]    <= s5_n[i];
      s6_prod[i] <= SCALE_W'(s5_n[i]) * $signed({{(SCALE_W-COORD_W){1'b0}}, s5_size});
    end
    result <= result_next;
  end

  `POBC_ASSERT_IMPL(a_latency, accept, ##LATENCY done)
  `POBC_ASSERT_IMPL(a_no_spurious, !accept, ##LATENCY !done)
  `POBC_ASSERT(a_miss_zero, (done && !result.hit) |-> (result == '0))

endmodule

[rtl/pobc_frame.sv]
// box frame transform: center subtract, rotation products, column dot sums
module pobc_frame (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  pobc_pkg::query_t                  query,
  input  logic [pobc_pkg::CFG_W-1:0]        center,
  input  pobc_pkg::axes_t                   axes,
  output logic                              out_valid,
  output pobc_pkg::frame_t                  frame
);
  import pobc_pkg::*;

  logic                     s1_valid;
  logic                     s2_valid;
  logic signed [DIFF_W-1:0] s1_d    [3];
  logic signed [PROD_W-1:0] s2_prod [3][3];
  logic signed [COORD_W-1:0] q      [3];
  logic [CFG_W-1:0]          col    [3];

  assign q[0]   = query.query_x;
  assign q[1]   = query.query_y;
  assign q[2]   = query.query_z;
  assign col[0] = axes.col_x;
  assign col[1] = axes.col_y;
  assign col[2] = axes.col_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
    for (int i = 0; i < 3; i++) begin
      s1_d[i] <= DIFF_W'(q[i]) - DIFF_W'(coord_elem(center, i));
    end
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        s2_prod[j][i] <= PROD_W'(s1_d[i]) * PROD_W'(rot_elem(col[j], i));
      end
    end
    frame.v_x <= LOC_W'(s2_prod[0][0]) + LOC_W'(s2_prod[0][1]) + LOC_W'(s2_prod[0][2]);
    frame.v_y <= LOC_W'(s2_prod[1][0]) + LOC_W'(s2_prod[1][1]) + LOC_W'(s2_prod[1][2]);
    frame.v_z <= LOC_W'(s2_prod[2][0]) + LOC_W'(s2_prod[2][1]) + LOC_W'(s2_prod[2][2]);
  end

endmodule
